>>> rtl/saw_pkg.sv
package saw_pkg;

    // Input event kinds.
    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_ACK    = 2'd3
    } t_kind;

    // Result types.
    localparam logic [1:0] TYPE_DATA  = 2'd0;
    localparam logic [1:0] TYPE_HELLO = 2'd1;
    localparam logic [1:0] TYPE_ACK   = 2'd2;

    // Configuration register indexes.
    localparam int CfgIndexW = 3;
    localparam logic [CfgIndexW-1:0] CFG_MY_ADDRESS     = 3'd0;
    localparam logic [CfgIndexW-1:0] CFG_PEER_ADDRESS   = 3'd1;
    localparam logic [CfgIndexW-1:0] CFG_START_DELAY    = 3'd2;
    localparam logic [CfgIndexW-1:0] CFG_NEXT_SEND      = 3'd3;
    localparam logic [CfgIndexW-1:0] CFG_HELLO_PERIOD   = 3'd4;
    localparam logic [CfgIndexW-1:0] CFG_RETX_TIMEOUT   = 3'd5;

    localparam int CfgDataW = 32;
    localparam int TimerW   = 16;

    // Result queue between front and back.
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    typedef struct packed {
        logic [1:0]  out_type;
        logic [31:0] sequence_num;
        logic [31:0] source;
        logic [31:0] destination;
        logic        last;
    } t_result;

    // What the front hands to the queue in one cycle: up to two results.
    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

>>> rtl/saw_front.sv
module saw_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [saw_pkg::CfgIndexW-1:0] i_cfg_index,
    input  logic [saw_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                          i_valid,
    input  logic                          i_q_busy,
    input  logic [1:0]                    i_kind,
    input  logic [31:0]                   i_rx_sequence,
    input  logic [31:0]                   i_rx_source,
    output saw_pkg::t_push                o_push
);

    logic [31:0]                r_my_address;
    logic [31:0]                r_peer_address;
    logic [saw_pkg::TimerW-1:0] r_start_delay;
    logic [saw_pkg::TimerW-1:0] r_next_send;
    logic [saw_pkg::TimerW-1:0] r_hello_period;
    logic [saw_pkg::TimerW-1:0] r_retx_timeout;

    logic [31:0]                r_send_seq, n_send_seq;
    logic [31:0]                r_hello_id, n_hello_id;
    logic                       r_data_armed, n_data_armed;
    logic [saw_pkg::TimerW-1:0] r_data_count, n_data_count;
    logic                       r_hello_armed, n_hello_armed;
    logic [saw_pkg::TimerW-1:0] r_hello_count, n_hello_count;

    logic             accept;
    logic             fire_data;
    logic             fire_hello;
    saw_pkg::t_kind   kind;
    saw_pkg::t_result data_res;
    saw_pkg::t_result hello_res;
    saw_pkg::t_result ack_res;

    // A period of zero behaves as one tick.
    function automatic logic [saw_pkg::TimerW-1:0] ticks_of(
        input logic [saw_pkg::TimerW-1:0] n
    );
        return (n == '0) ? saw_pkg::TimerW'(1) : n;
    endfunction

    assign accept = i_valid && !i_q_busy;
    assign kind   = saw_pkg::t_kind'(i_kind);

    // An armed timer always holds a count of one or more, so it fires at one.
    assign fire_data  = r_data_armed && (r_data_count == saw_pkg::TimerW'(1));
    assign fire_hello = r_hello_armed && (r_hello_count == saw_pkg::TimerW'(1));

    always_comb begin
        data_res.out_type     = saw_pkg::TYPE_DATA;
        data_res.sequence_num = r_send_seq;
        data_res.source       = r_my_address;
        data_res.destination  = r_peer_address;
        data_res.last         = !fire_hello;

        hello_res.out_type     = saw_pkg::TYPE_HELLO;
        hello_res.sequence_num = r_hello_id + 32'd1;
        hello_res.source       = r_my_address;
        hello_res.destination  = '0;
        hello_res.last         = 1'b1;

        ack_res.out_type     = saw_pkg::TYPE_ACK;
        ack_res.sequence_num = i_rx_sequence;
        ack_res.source       = r_my_address;
        ack_res.destination  = i_rx_source;
        ack_res.last         = 1'b1;
    end

    always_comb begin
        n_send_seq    = r_send_seq;
        n_hello_id    = r_hello_id;
        n_data_armed  = r_data_armed;
        n_data_count  = r_data_count;
        n_hello_armed = r_hello_armed;
        n_hello_count = r_hello_count;
        o_push.num    = 2'd0;
        o_push.first  = data_res;
        o_push.second = hello_res;

        if (accept) begin
            case (kind)
                saw_pkg::KIND_START: begin
                    if (r_start_delay != '0) begin
                        n_data_armed = 1'b1;
                        n_data_count = r_start_delay;
                    end
                    n_hello_armed = 1'b1;
                    n_hello_count = ticks_of(r_hello_period);
                end
                saw_pkg::KIND_TICK: begin
                    if (fire_data) begin
                        n_data_count = ticks_of(r_retx_timeout);
                    end else if (r_data_armed) begin
                        n_data_count = r_data_count - saw_pkg::TimerW'(1);
                    end
                    if (fire_hello) begin
                        n_hello_id    = r_hello_id + 32'd1;
                        n_hello_count = ticks_of(r_hello_period);
                    end else if (r_hello_armed) begin
                        n_hello_count = r_hello_count - saw_pkg::TimerW'(1);
                    end
                    if (fire_data && fire_hello) begin
                        o_push.num = 2'd2;
                    end else if (fire_data) begin
                        o_push.num = 2'd1;
                    end else if (fire_hello) begin
                        o_push.num   = 2'd1;
                        o_push.first = hello_res;
                    end
                end
                saw_pkg::KIND_DATA: begin
                    o_push.num   = 2'd1;
                    o_push.first = ack_res;
                end
                saw_pkg::KIND_ACK: begin
                    if (i_rx_sequence == r_send_seq) begin
                        n_send_seq   = r_send_seq + 32'd1;
                        n_data_armed = 1'b1;
                        n_data_count = ticks_of(r_next_send);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_address   <= '0;
            r_peer_address <= '0;
            r_start_delay  <= '0;
            r_next_send    <= saw_pkg::TimerW'(3);
            r_hello_period <= saw_pkg::TimerW'(2);
            r_retx_timeout <= saw_pkg::TimerW'(1);
            r_send_seq     <= '0;
            r_hello_id     <= '0;
            r_data_armed   <= 1'b0;
            r_data_count   <= '0;
            r_hello_armed  <= 1'b0;
            r_hello_count  <= '0;
        end else begin
            r_send_seq    <= n_send_seq;
            r_hello_id    <= n_hello_id;
            r_data_armed  <= n_data_armed;
            r_data_count  <= n_data_count;
            r_hello_armed <= n_hello_armed;
            r_hello_count <= n_hello_count;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    saw_pkg::CFG_MY_ADDRESS:   r_my_address   <= i_cfg_data;
                    saw_pkg::CFG_PEER_ADDRESS: r_peer_address <= i_cfg_data;
                    saw_pkg::CFG_START_DELAY:
                        r_start_delay  <= i_cfg_data[saw_pkg::TimerW-1:0];
                    saw_pkg::CFG_NEXT_SEND:
                        r_next_send    <= i_cfg_data[saw_pkg::TimerW-1:0];
                    saw_pkg::CFG_HELLO_PERIOD:
                        r_hello_period <= i_cfg_data[saw_pkg::TimerW-1:0];
                    saw_pkg::CFG_RETX_TIMEOUT:
                        r_retx_timeout <= i_cfg_data[saw_pkg::TimerW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

>>> rtl/saw_queue.sv
module saw_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  saw_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_busy,
    output logic             o_head_valid,
    output saw_pkg::t_result o_head
);

    saw_pkg::t_result                r_entry [saw_pkg::QueueDepth];
    logic [saw_pkg::QueuePtrW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [saw_pkg::QueuePtrW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [saw_pkg::QueueCntW-1:0]   r_count, n_count;
    logic [saw_pkg::QueuePtrW-1:0]   wr_ptr_next;
    logic                            pop;

    // The front may hand over two results at once, so it waits for two free slots.
    assign o_busy       = r_count > saw_pkg::QueueCntW'(saw_pkg::QueueDepth - 2);
    assign o_head_valid = r_count != '0;
    assign o_head       = r_entry[r_rd_ptr];
    assign pop          = i_pop && o_head_valid;
    assign wr_ptr_next  = r_wr_ptr + saw_pkg::QueuePtrW'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + saw_pkg::QueuePtrW'(i_push.num);
        n_rd_ptr = pop ? r_rd_ptr + saw_pkg::QueuePtrW'(1) : r_rd_ptr;
        n_count  = r_count + saw_pkg::QueueCntW'(i_push.num)
                   - saw_pkg::QueueCntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_entry[r_wr_ptr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_entry[wr_ptr_next] <= i_push.second;
        end
    end

endmodule

>>> rtl/saw_back.sv
module saw_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  saw_pkg::t_result i_head,
    output logic             o_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output saw_pkg::t_result o_item
);

    logic             r_valid;
    saw_pkg::t_result r_item;

    // Refill the output register whenever it is empty or its beat leaves now.
    assign o_pop   = i_head_valid && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
    end

endmodule

>>> rtl/stop_and_wait_arq_endpoint.sv
// Stop-and-wait ARQ endpoint.
// Input channel (i_in_valid / o_in_stall) carries one event per beat: start,
// timer tick, received data or received ack. Output channel (o_out_valid /
// i_out_stall) carries the headers to send: DATA, HELLO or ACK, with o_out_last
// marking the last result caused by one event.
// The front updates the timers and sequence state in the cycle it takes an
// event and writes zero, one or two results into a four-entry queue. The back
// moves one result per cycle from the queue into the output register.
// An event is taken every cycle as long as the queue has two free slots.
// A result is registered in the queue and then in the output register. Events
// that make two results (both timers firing on one tick) leave the queue one
// at a time, so a long run of them fills the queue and stalls the input. When
// the receiver stalls, the output beat holds and the queue fills; the input
// stalls once fewer than two slots remain free. Reset clears the state, empties
// the queue and the output register, and loads the register defaults. Registers
// are to be written through the cfg port while idle, unenforced by the block.
module stop_and_wait_arq_endpoint (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [saw_pkg::CfgIndexW-1:0] i_cfg_index,
    input  logic [saw_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_kind,
    input  logic [31:0]                   i_rx_sequence,
    input  logic [31:0]                   i_rx_source,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_out_type,
    output logic [31:0]                   o_out_sequence,
    output logic [31:0]                   o_out_source,
    output logic [31:0]                   o_out_destination,
    output logic                          o_out_last
);

    saw_pkg::t_push   push;
    saw_pkg::t_result head;
    saw_pkg::t_result out_item;
    logic             q_busy;
    logic             head_valid;
    logic             pop;

    assign o_in_stall = q_busy;

    saw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_in_valid),
        .i_q_busy      (q_busy),
        .i_kind        (i_kind),
        .i_rx_sequence (i_rx_sequence),
        .i_rx_source   (i_rx_source),
        .o_push        (push)
    );

    saw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop        (pop),
        .o_busy       (q_busy),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    saw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_stall      (i_out_stall),
        .o_valid      (o_out_valid),
        .o_item       (out_item)
    );

    assign o_out_type        = out_item.out_type;
    assign o_out_sequence    = out_item.sequence_num;
    assign o_out_source      = out_item.source;
    assign o_out_destination = out_item.destination;
    assign o_out_last        = out_item.last;

endmodule
